// ----- rtl/utt_pkg.sv -----
// ----------------------------------------------------------------------------
// utt_pkg
// Shared types, constants and helpers for the unicycle trajectory tracker.
// ----------------------------------------------------------------------------
package utt_pkg;

  localparam int CordicStepsDefault = 16;
  localparam int DivSteps           = 32;

  localparam logic [15:0] PosGainReset   = 16'd2458;
  localparam logic [15:0] VelGainReset   = 16'd2048;
  localparam logic [31:0] InitSpeedReset = 32'd655;
  localparam logic [30:0] TurnLimitReset = 31'd32768;

  // inverse CORDIC gain, Q2.30
  localparam logic signed [32:0] GainInv = 33'sd652032874;
  localparam logic [31:0]        OneQ16  = 32'd65536;

  typedef enum logic [1:0] {
    REG_POS_GAIN  = 2'd0,
    REG_VEL_GAIN  = 2'd1,
    REG_INIT_SPD  = 2'd2,
    REG_TURN_LIM  = 2'd3
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PD_KPX,
    ST_PD_KDX,
    ST_PD_KPY,
    ST_PD_KDY,
    ST_PD_END,
    ST_ROT,
    ST_CORDIC,
    ST_GAIN_A,
    ST_GAIN_B,
    ST_GAIN_END,
    ST_DIV_INIT,
    ST_SPEED,
    ST_DIV_WAIT,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic        [31:0] timestamp;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] des_pos_x;
    logic signed [31:0] des_pos_y;
    logic signed [31:0] des_vel_x;
    logic signed [31:0] des_vel_y;
    logic signed [31:0] des_acc_x;
    logic signed [31:0] des_acc_y;
  } in_t;

  typedef struct packed {
    logic signed [31:0] linear_speed;
    logic signed [31:0] turn_rate;
  } out_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  function automatic logic signed [31:0] sat32(input logic signed [71:0] v);
    if (v > 72'sd2147483647)       return 32'sh7fffffff;
    else if (v < -72'sd2147483648) return 32'sh80000000;
    else                           return v[31:0];
  endfunction

endpackage

// ----- rtl/unicycle_trajectory_tracker_unit.sv -----
// ----------------------------------------------------------------------------
// unicycle_trajectory_tracker_unit
// Per item, in order: the PD states, a rotation setup state, the CORDIC
// vectoring steps, the gain states, the divider setup and speed states,
// the divide and an output state; the CORDIC and gain stages are skipped
// when vel_y is zero. A new item is taken only once the sequencer is idle;
// the shared multiplier, the CORDIC step loop and the one-bit-a-cycle divider
// set the pace. An item that only records its timestamp gives no result.
// Reset: synchronous; registers to defaults, stored time zero, speed 655.
// ----------------------------------------------------------------------------
module unicycle_trajectory_tracker_unit import utt_pkg::*; #(
  parameter int CORDIC_STEPS = CordicStepsDefault
) (
  input  logic        clk,
  input  logic        rst,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  in_t         in_item,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output out_t        out_item,
  // APB-style configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int StepW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;

  // ---- configuration registers ----
  logic        [15:0] pos_gain;
  logic        [15:0] vel_gain;
  logic signed [31:0] init_speed;
  logic        [30:0] turn_lim;
  logic               cfg_wr;
  reg_idx_t           cfg_idx;

  // ---- state ----
  state_t             state, state_next;
  logic        [31:0] prev_time;
  logic signed [31:0] spd;

  // ---- datapath ----
  in_t                item;
  logic        [31:0] dt;
  logic signed [51:0] acc1, acc2, acc2_fin;
  logic signed [31:0] v1, v2, f, l;
  logic signed [35:0] cx, cy, ca, cb;
  logic [StepW-1:0]   cnt;
  logic signed [68:0] prod;
  logic signed [35:0] mul_a;
  logic signed [32:0] mul_b;
  logic               q_neg;

  // ---- control decodes ----
  logic               in_xfer;
  logic               out_load;
  logic               div_start;
  logic               cordic_last;
  logic               cw;

  // ---- divider ----
  logic        [31:0] lmag, dmag;
  logic        [32:0] l_abs;
  logic        [32:0] s_abs;
  div_stat_t          div_stat;
  logic        [31:0] quo;
  logic        [31:0] q_mag;
  logic        [31:0] q_clamped;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_t'(paddr[3:2]);
  assign in_xfer = in_valid && !in_stall;

  // register read-back
  always_comb begin
    unique case (cfg_idx)
      REG_POS_GAIN: prdata = {16'd0, pos_gain};
      REG_VEL_GAIN: prdata = {16'd0, vel_gain};
      REG_INIT_SPD: prdata = init_speed;
      REG_TURN_LIM: prdata = {1'b0, turn_lim};
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_gain   <= PosGainReset;
      vel_gain   <= VelGainReset;
      init_speed <= InitSpeedReset;
      turn_lim   <= TurnLimitReset;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_POS_GAIN: pos_gain   <= pwdata[15:0];
        REG_VEL_GAIN: vel_gain   <= pwdata[15:0];
        REG_INIT_SPD: init_speed <= pwdata;
        REG_TURN_LIM: turn_lim   <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  // ---- sequencer: next state ----
  assign cordic_last = (cnt == StepW'(CORDIC_STEPS - 1));

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:     if (in_xfer && prev_time != '0) state_next = ST_PD_KPX;
      ST_PD_KPX:   state_next = ST_PD_KDX;
      ST_PD_KDX:   state_next = ST_PD_KPY;
      ST_PD_KPY:   state_next = ST_PD_KDY;
      ST_PD_KDY:   state_next = ST_PD_END;
      ST_PD_END:   state_next = ST_ROT;
      ST_ROT:      state_next = (item.vel_y == '0) ? ST_DIV_INIT : ST_CORDIC;
      ST_CORDIC:   if (cordic_last) state_next = ST_GAIN_A;
      ST_GAIN_A:   state_next = ST_GAIN_B;
      ST_GAIN_B:   state_next = ST_GAIN_END;
      ST_GAIN_END: state_next = ST_DIV_INIT;
      ST_DIV_INIT: state_next = ST_SPEED;
      ST_SPEED:    state_next = ST_DIV_WAIT;
      ST_DIV_WAIT: if (div_stat.done) state_next = ST_DONE;
      ST_DONE:     if (out_load) state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // ---- sequencer: outputs and shared multiplier operands ----
  always_comb begin
    in_stall  = (state != ST_IDLE);
    div_start = (state == ST_DIV_INIT);
    out_load  = (state == ST_DONE) && (!out_valid || !out_stall);
    mul_a     = '0;
    mul_b     = '0;
    unique case (state)
      ST_PD_KPX: begin
        mul_a = 36'($signed({item.pos_x[31], item.pos_x})
                    - $signed({item.des_pos_x[31], item.des_pos_x}));
        mul_b = $signed({17'd0, pos_gain});
      end
      ST_PD_KDX: begin
        mul_a = 36'($signed({item.vel_x[31], item.vel_x})
                    - $signed({item.des_vel_x[31], item.des_vel_x}));
        mul_b = $signed({17'd0, vel_gain});
      end
      ST_PD_KPY: begin
        mul_a = 36'($signed({item.pos_y[31], item.pos_y})
                    - $signed({item.des_pos_y[31], item.des_pos_y}));
        mul_b = $signed({17'd0, pos_gain});
      end
      ST_PD_KDY: begin
        mul_a = 36'($signed({item.vel_y[31], item.vel_y})
                    - $signed({item.des_vel_y[31], item.des_vel_y}));
        mul_b = $signed({17'd0, vel_gain});
      end
      ST_GAIN_A: begin
        mul_a = ca;
        mul_b = GainInv;
      end
      ST_GAIN_B: begin
        mul_a = cb;
        mul_b = GainInv;
      end
      ST_DIV_INIT: begin
        mul_a = 36'(f);
        mul_b = $signed({1'b0, dt});
      end
      default: ;
    endcase
  end

  // ---- divider operands: speed before this update, magnitude >= 1.0 ----
  assign l_abs = l[31] ? 33'(-$signed({l[31], l})) : {1'b0, l};
  assign s_abs = spd[31] ? 33'(-$signed({spd[31], spd})) : {1'b0, spd};
  assign lmag  = l_abs[31:0];
  assign dmag  = (s_abs < {1'b0, OneQ16}) ? OneQ16 : s_abs[31:0];

  utt_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .lmag  (lmag),
    .dmag  (dmag),
    .stat  (div_stat),
    .quo   (quo)
  );

  assign q_mag     = quo;
  assign q_clamped = (q_mag > {1'b0, turn_lim}) ? {1'b0, turn_lim} : q_mag;

  assign acc2_fin = acc2 - $signed(prod[51:0]);
  assign cw       = !cy[35];

  // ---- control state: stored time, speed integrator, result register ----
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_time <= '0;
      spd       <= InitSpeedReset;
      out_valid <= 1'b0;
    end else begin
      if (in_xfer) prev_time <= in_item.timestamp;
      if (cfg_wr && cfg_idx == REG_INIT_SPD) begin
        spd <= pwdata;
      end else if (state == ST_SPEED) begin
        spd <= sat32(72'(spd) + 72'(prod >>> 16));
      end
      if (out_load)                    out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
    end
  end

  // ---- datapath ----
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    if (in_xfer) begin
      item <= in_item;
      dt   <= in_item.timestamp - prev_time;
    end
    unique case (state)
      ST_PD_KDX: acc1 <= (52'(item.des_acc_x) <<< 12) - $signed(prod[51:0]);
      ST_PD_KPY: acc1 <= acc1 - $signed(prod[51:0]);
      ST_PD_KDY: acc2 <= (52'(item.des_acc_y) <<< 12) - $signed(prod[51:0]);
      ST_PD_END: begin
        v1 <= sat32(72'(acc1 >>> 12));
        v2 <= sat32(72'(acc2_fin >>> 12));
      end
      ST_ROT: begin
        // no rotation when heading is zero or pi, or velocity is zero
        f   <= v1;
        l   <= v2;
        cnt <= '0;
        if (item.vel_x[31]) begin
          cx <= -36'(item.vel_x);
          cy <= -36'(item.vel_y);
          ca <= -36'(v1);
          cb <= -36'(v2);
        end else begin
          cx <= 36'(item.vel_x);
          cy <= 36'(item.vel_y);
          ca <= 36'(v1);
          cb <= 36'(v2);
        end
      end
      ST_CORDIC: begin
        cnt <= cnt + 1'b1;
        if (cw) begin
          cx <= cx + (cy >>> cnt);
          cy <= cy - (cx >>> cnt);
          ca <= ca + (cb >>> cnt);
          cb <= cb - (ca >>> cnt);
        end else begin
          cx <= cx - (cy >>> cnt);
          cy <= cy + (cx >>> cnt);
          ca <= ca - (cb >>> cnt);
          cb <= cb + (ca >>> cnt);
        end
      end
      ST_GAIN_B:   f <= sat32(72'(prod >>> 30));
      ST_GAIN_END: l <= sat32(72'(prod >>> 30));
      ST_DIV_INIT: q_neg <= l[31] ^ spd[31];
      default: ;
    endcase
    if (out_load) begin
      out_item.linear_speed <= spd;
      out_item.turn_rate    <= q_neg ? -$signed(q_clamped) : $signed(q_clamped);
    end
  end

  // ---- assertions ----
  a_div_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    div_stat.done |-> state == ST_DIV_WAIT)
    else $error("divider finished outside its wait state");

  a_turn_within_limit: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_item.turn_rate <= $signed({1'b0, turn_lim}))
               && (out_item.turn_rate >= -$signed({1'b0, turn_lim})))
    else $error("turn rate beyond limit");

  a_start_after_xfer: assert property (@(posedge clk) disable iff (rst)
    (in_xfer && prev_time != '0) |=> state == ST_PD_KPX)
    else $error("transfer did not start the sequence");

endmodule

// ----- rtl/utt_div.sv -----
// ----------------------------------------------------------------------------
// utt_div
// Radix-2 restoring divider: (lmag * 2^16) / dmag, one quotient bit a cycle.
// Requires lmag[31:16] < dmag so the quotient fits 32 bits.
// ----------------------------------------------------------------------------
module utt_div import utt_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] lmag,
  input  logic [31:0] dmag,
  output div_stat_t   stat,
  output logic [31:0] quo
);

  localparam int CntW = $clog2(DivSteps);

  logic [31:0]     rem;
  logic [31:0]     shreg;
  logic [31:0]     den;
  logic [CntW-1:0] cnt;
  logic            busy;
  logic            done;
  logic [32:0]     trial;
  logic            fits;

  assign trial = {rem, shreg[31]};
  assign fits  = trial >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CntW'(DivSteps - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= {16'd0, lmag[31:16]};
      shreg <= {lmag[15:0], 16'd0};
      den   <= dmag;
    end else if (busy) begin
      rem   <= fits ? 32'(trial - {1'b0, den}) : trial[31:0];
      shreg <= {shreg[30:0], fits};
    end
  end

  assign stat = '{busy: busy, done: done};
  assign quo  = shreg;

endmodule
